FILE: rtl/jbp_pkg.sv
// Shared types, constants and helpers for the JSON byte prevalidator.
package jbp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DEPTH_W = 4;
  localparam int unsigned SEP_W   = 8;
  localparam int unsigned CP_W    = 21;

  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RESET   = 4'd8;
  localparam logic [SEP_W-1:0]   MAX_MEMBERS_RESET = 8'd128;

  // UTF-8 lead ranges and code point limits
  localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;

  localparam logic [CP_W-1:0] CP_MIN_3BYTE = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4BYTE = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;

  // fourth zero after \u means \u0000
  localparam logic [2:0] UZC_FAIL = 3'd5;

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_UPPERE = 8'h45;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LOWERE = 8'h65;
  localparam logic [BYTE_W-1:0] CH_LOWERU = 8'h75;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;

  typedef enum logic {
    CFG_MAX_DEPTH   = 1'b0,
    CFG_MAX_MEMBERS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    NUM_NONE  = 2'd0,
    NUM_MINUS = 2'd1,
    NUM_ZERO  = 2'd2,
    NUM_INT   = 2'd3
  } num_phase_t;

  typedef struct packed {
    logic               failed;
    logic               in_string;
    logic               escape_pending;
    logic [2:0]         unicode_zero_count;
    logic [1:0]         utf8_remaining;
    logic [1:0]         utf8_length;
    logic [CP_W-1:0]    code_point;
    logic [DEPTH_W-1:0] nesting_depth;
    logic [SEP_W-1:0]   separator_count;
    num_phase_t         number_phase;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    failed:             1'b0,
    in_string:          1'b0,
    escape_pending:     1'b0,
    unicode_zero_count: 3'd0,
    utf8_remaining:     2'd0,
    utf8_length:        2'd0,
    code_point:         '0,
    nesting_depth:      '0,
    separator_count:    '0,
    number_phase:       NUM_NONE
  };

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // verdict for a message whose last byte left the scanner in state s
  function automatic logic verdict_ok(input scan_state_t s);
    return !s.failed && !s.in_string && !s.escape_pending &&
           (s.utf8_remaining == 2'd0) && (s.nesting_depth == '0) &&
           (s.number_phase != NUM_MINUS);
  endfunction

endpackage

FILE: rtl/json_byte_prevalidator.sv
// Top level: one byte per transaction in, a verdict per message out, with skid buffering.
// Each verdict is registered into the out or skid register as its last byte is taken.
// One byte per cycle while in_stall is low; scanner state is one register updated by one step.
// in_stall rises only while a second verdict waits behind a stalled one (skid stage full).
// Synchronous active-low reset clears scanner state and output buffer, and sets
// max_depth to 8 and max_members to 128; the scanner state also clears after each last byte.
module json_byte_prevalidator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [jbp_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [jbp_pkg::SEP_W-1:0]   cfg_data
);

  jbp_pkg::scan_state_t            state_r, state_nxt, step_nxt;
  logic [jbp_pkg::DEPTH_W-1:0]     max_depth_r, max_depth_nxt;
  logic [jbp_pkg::SEP_W-1:0]       max_members_r, max_members_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_acc_r, out_acc_nxt;
  logic                            skid_valid_r, skid_valid_nxt;
  logic                            skid_acc_r, skid_acc_nxt;
  logic                            in_fire, out_pop, res_valid, res_acc;

  jbp_step u_step (
    .cur         (state_r),
    .data_byte   (in_data_byte),
    .max_depth   (max_depth_r),
    .max_members (max_members_r),
    .nxt         (step_nxt)
  );

  assign in_stall     = skid_valid_r;
  assign in_fire      = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_pop      = out_valid_r && !out_stall;
  assign cfg_ready    = 1'b1;
  assign res_valid    = in_fire && in_last_byte;
  assign res_acc      = jbp_pkg::verdict_ok(step_nxt);

  always_comb begin
    max_depth_nxt   = max_depth_r;
    max_members_nxt = max_members_r;
    if (cfg_valid && cfg_ready) begin
      unique case (jbp_pkg::cfg_idx_t'(cfg_index))
        jbp_pkg::CFG_MAX_DEPTH:   max_depth_nxt   = cfg_data[jbp_pkg::DEPTH_W-1:0];
        jbp_pkg::CFG_MAX_MEMBERS: max_members_nxt = cfg_data;
        default:                  max_depth_nxt   = max_depth_r;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (in_fire) state_nxt = in_last_byte ? jbp_pkg::SCAN_RESET : step_nxt;
  end

  // two-entry output buffer: out register in front, skid register behind
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_acc_nxt    = out_acc_r;
    skid_valid_nxt = skid_valid_r;
    skid_acc_nxt   = skid_acc_r;
    if (skid_valid_r) begin
      if (out_pop) begin
        out_valid_nxt  = 1'b1;
        out_acc_nxt    = skid_acc_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (out_valid_r && !out_pop) begin
      if (res_valid) begin
        skid_valid_nxt = 1'b1;
        skid_acc_nxt   = res_acc;
      end
    end else begin
      out_valid_nxt = res_valid;
      if (res_valid) out_acc_nxt = res_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= jbp_pkg::SCAN_RESET;
      max_depth_r   <= jbp_pkg::MAX_DEPTH_RESET;
      max_members_r <= jbp_pkg::MAX_MEMBERS_RESET;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      max_depth_r   <= max_depth_nxt;
      max_members_r <= max_members_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r  <= out_acc_nxt;
    skid_acc_r <= skid_acc_nxt;
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> state_r == jbp_pkg::SCAN_RESET)
    else $error("scanner state not cleared after last byte");

  a_utf8_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.failed |-> state_r.utf8_remaining <= state_r.utf8_length)
    else $error("more continuation bytes due than sequence length");

  a_uzc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.failed |-> state_r.unicode_zero_count < jbp_pkg::UZC_FAIL)
    else $error("escape zero count past limit without failure");
`endif

endmodule

FILE: rtl/jbp_step.sv
// Next-state logic of the byte scanner: one message byte against the current state.
module jbp_step (
  input  jbp_pkg::scan_state_t             cur,
  input  logic [jbp_pkg::BYTE_W-1:0]       data_byte,
  input  logic [jbp_pkg::DEPTH_W-1:0]      max_depth,
  input  logic [jbp_pkg::SEP_W-1:0]        max_members,
  output jbp_pkg::scan_state_t             nxt
);

  logic [jbp_pkg::BYTE_W-1:0] c;
  logic [jbp_pkg::CP_W-1:0]   cp_shift;
  logic [2:0]                 uzc_inc;
  logic                       uzc_stop;
  logic                       num_stop;
  logic                       seq_bad;

  assign c        = data_byte;
  assign cp_shift = {cur.code_point[jbp_pkg::CP_W-7:0], c[5:0]};
  assign uzc_inc  = cur.unicode_zero_count + 3'd1;
  assign seq_bad  = ((cur.utf8_length == 2'd2) && (cp_shift < jbp_pkg::CP_MIN_3BYTE)) ||
                    ((cur.utf8_length == 2'd3) && (cp_shift < jbp_pkg::CP_MIN_4BYTE)) ||
                    (cp_shift > jbp_pkg::CP_MAX) ||
                    ((cp_shift >= jbp_pkg::CP_SURR_LO) && (cp_shift <= jbp_pkg::CP_SURR_HI)) ||
                    !cur.in_string;

  always_comb begin
    nxt      = cur;
    uzc_stop = 1'b0;
    num_stop = 1'b0;
    if (!cur.failed) begin
      if (c == jbp_pkg::CH_NUL) begin
        nxt.failed = 1'b1;
      end else if (cur.utf8_remaining != 2'd0) begin
        // continuation byte
        if (c[7:6] != 2'b10) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.code_point     = cp_shift;
          nxt.utf8_remaining = cur.utf8_remaining - 2'd1;
          if ((cur.utf8_remaining == 2'd1) && seq_bad) nxt.failed = 1'b1;
        end
      end else begin
        if (cur.in_string && (cur.unicode_zero_count != 3'd0)) begin
          if (c == jbp_pkg::CH_ZERO) begin
            nxt.unicode_zero_count = uzc_inc;
            if (uzc_inc >= jbp_pkg::UZC_FAIL) begin
              nxt.failed = 1'b1;
              uzc_stop   = 1'b1;
            end
          end else begin
            nxt.unicode_zero_count = 3'd0;
          end
        end
        if (!uzc_stop) begin
          if (cur.escape_pending) begin
            nxt.escape_pending = 1'b0;
            if (c == jbp_pkg::CH_LOWERU) nxt.unicode_zero_count = 3'd1;
          end else begin
            if (cur.number_phase != jbp_pkg::NUM_NONE) begin
              num_stop = 1'b1;
              if (cur.number_phase == jbp_pkg::NUM_MINUS) begin
                if (!jbp_pkg::is_digit(c)) nxt.failed = 1'b1;
                else if (c == jbp_pkg::CH_ZERO) nxt.number_phase = jbp_pkg::NUM_ZERO;
                else nxt.number_phase = jbp_pkg::NUM_INT;
              end else if (jbp_pkg::is_digit(c)) begin
                if (cur.number_phase == jbp_pkg::NUM_ZERO) nxt.failed = 1'b1;
              end else if ((c == jbp_pkg::CH_DOT) || (c == jbp_pkg::CH_LOWERE) ||
                           (c == jbp_pkg::CH_UPPERE)) begin
                nxt.failed = 1'b1;
              end else begin
                // number ended: fall through and treat the byte normally
                nxt.number_phase = jbp_pkg::NUM_NONE;
                num_stop         = 1'b0;
              end
            end
            if (!num_stop) begin
              if (c[7]) begin
                priority if ((c >= jbp_pkg::LEAD2_LO) && (c <= jbp_pkg::LEAD2_HI)) begin
                  nxt.code_point     = {{(jbp_pkg::CP_W-5){1'b0}}, c[4:0]};
                  nxt.utf8_length    = 2'd1;
                  nxt.utf8_remaining = 2'd1;
                end else if ((c >= jbp_pkg::LEAD3_LO) && (c <= jbp_pkg::LEAD3_HI)) begin
                  nxt.code_point     = {{(jbp_pkg::CP_W-4){1'b0}}, c[3:0]};
                  nxt.utf8_length    = 2'd2;
                  nxt.utf8_remaining = 2'd2;
                end else if ((c >= jbp_pkg::LEAD4_LO) && (c <= jbp_pkg::LEAD4_HI)) begin
                  nxt.code_point     = {{(jbp_pkg::CP_W-3){1'b0}}, c[2:0]};
                  nxt.utf8_length    = 2'd3;
                  nxt.utf8_remaining = 2'd3;
                end else begin
                  nxt.failed = 1'b1;
                end
              end else if (cur.in_string) begin
                priority if (c < jbp_pkg::CTRL_LIMIT) nxt.failed = 1'b1;
                else if (c == jbp_pkg::CH_QUOTE) nxt.in_string = 1'b0;
                else if (c == jbp_pkg::CH_BSLASH) nxt.escape_pending = 1'b1;
                else nxt.in_string = cur.in_string;
              end else begin
                priority if ((c == jbp_pkg::CH_COLON) || (c == jbp_pkg::CH_COMMA)) begin
                  if (cur.separator_count >= max_members) nxt.failed = 1'b1;
                  else nxt.separator_count = cur.separator_count + 8'd1;
                end else if (c == jbp_pkg::CH_QUOTE) begin
                  nxt.in_string = 1'b1;
                end else if ((c == jbp_pkg::CH_LBRACE) || (c == jbp_pkg::CH_LBRACK)) begin
                  if (cur.nesting_depth >= max_depth) nxt.failed = 1'b1;
                  else nxt.nesting_depth = cur.nesting_depth + 4'd1;
                end else if ((c == jbp_pkg::CH_RBRACE) || (c == jbp_pkg::CH_RBRACK)) begin
                  if (cur.nesting_depth == '0) nxt.failed = 1'b1;
                  else nxt.nesting_depth = cur.nesting_depth - 4'd1;
                end else if (c == jbp_pkg::CH_MINUS) begin
                  nxt.number_phase = jbp_pkg::NUM_MINUS;
                end else if (jbp_pkg::is_digit(c)) begin
                  nxt.number_phase = (c == jbp_pkg::CH_ZERO) ? jbp_pkg::NUM_ZERO
                                                              : jbp_pkg::NUM_INT;
                end else if ((c == jbp_pkg::CH_PLUS) || (c == jbp_pkg::CH_DOT) ||
                             ((c < jbp_pkg::CTRL_LIMIT) && (c != jbp_pkg::CH_TAB) &&
                              (c != jbp_pkg::CH_CR) && (c != jbp_pkg::CH_LF))) begin
                  nxt.failed = 1'b1;
                end else begin
                  nxt.failed = cur.failed;
                end
              end
            end
          end
        end
      end
    end
  end

endmodule
